// File: design/fdn_pkg.sv
// Package for the FAT directory entry name decoder.
// Holds the stream widths, FAT byte codes, the sequencer state type and the 8.3 name record.
// No dependencies; every other design file imports it.
package fdn_pkg;

    // Stream layout.
    localparam int ENTRY_W     = 256;
    localparam int IN_TDATA_W  = 264;
    localparam int NEW_DIR_BIT = 256;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_PAD_W   = 7;

    // Field widths.
    localparam int CHAR_W     = 8;
    localparam int CHAR_POS_W = 6;
    localparam int WORD_W     = 32;
    localparam int UNIT_W     = 16;
    localparam int SFN_MAX    = 12;
    localparam int SFN_LEN_W  = 4;
    localparam int LFN_POS_W  = 9;
    localparam int UNIT_IDX_W = 4;
    localparam int SEQ_W      = 5;

    localparam int UNITS_PER_ENTRY = 13;
    localparam logic [UNIT_IDX_W-1:0] UNIT_LAST = UNIT_IDX_W'(UNITS_PER_ENTRY - 1);

    // FAT byte codes.
    localparam logic [CHAR_W-1:0] BYTE_END       = 8'h00;
    localparam logic [CHAR_W-1:0] BYTE_DELETED   = 8'hE5;
    localparam logic [CHAR_W-1:0] BYTE_DOT       = 8'h2E;
    localparam logic [CHAR_W-1:0] BYTE_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR_LONG      = 8'h0F;
    localparam logic [CHAR_W-1:0] ATTR_VOLUME    = 8'h08;
    localparam logic [CHAR_W-1:0] ATTR_DIRECTORY = 8'h10;
    localparam logic [UNIT_W-1:0] UNIT_EMPTY     = 16'h0000;
    localparam logic [UNIT_W-1:0] UNIT_PAD       = 16'hFFFF;

    // Byte offset of the low byte of each UTF-16 unit in a long-name entry.
    localparam logic [4:0] UNIT_OFFSET [0:UNITS_PER_ENTRY-1] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LFN_WRITE,
        ST_LONG_SCAN,
        ST_SHORT_EMIT,
        ST_END_MARK
    } fsm_state_t;

    // Formatted 8.3 name: characters from index 0 up, and the displayed length.
    typedef struct packed {
        logic [SFN_MAX-1:0][CHAR_W-1:0] chars;
        logic [SFN_LEN_W-1:0]           len;
    } sfn_t;

endpackage

// File: design/fdn_name_ram.sv
// Long-name character buffer: one write port, one registered read port.
// Each entry has a valid bit so the whole buffer reads as zero after a clear.
// Depends on fdn_pkg.
module fdn_name_ram #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import fdn_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: design/fdn_short_name.sv
// 8.3 name formatter: trims the base and extension, inserts the dot,
// and cuts the name at the first zero byte. Depends on fdn_pkg.
module fdn_short_name (
    input  logic [10:0][7:0] name_bytes,
    output fdn_pkg::sfn_t    sfn
);
    import fdn_pkg::*;

    logic [SFN_MAX-1:0][CHAR_W-1:0] padded;

    assign padded = {CHAR_W'(0), name_bytes};

    always_comb begin
        logic [SFN_LEN_W-1:0] stem_len;
        logic [1:0]           ext_len;
        logic                 has_ext;
        logic                 stop;
        logic [SFN_LEN_W-1:0] rel;

        stem_len = SFN_LEN_W'(8);
        stop     = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!stop && padded[k] == BYTE_SPACE) begin
                stem_len = SFN_LEN_W'(k);
                stop     = 1'b1;
            end
        end

        has_ext = (padded[8] != BYTE_SPACE);
        ext_len = 2'd3;
        stop    = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (!stop && padded[8 + j] == BYTE_SPACE) begin
                ext_len = 2'(j);
                stop    = 1'b1;
            end
        end

        // Each output slot picks a base byte, the dot, an extension byte or zero.
        for (int k = 0; k < SFN_MAX; k++) begin
            rel = SFN_LEN_W'(k) - stem_len;
            if (SFN_LEN_W'(k) < stem_len) begin
                sfn.chars[k] = padded[k];
            end else if (has_ext && rel == '0) begin
                sfn.chars[k] = BYTE_DOT;
            end else if (has_ext && rel <= {2'b00, ext_len}) begin
                case (rel)
                    4'd1:    sfn.chars[k] = padded[8];
                    4'd2:    sfn.chars[k] = padded[9];
                    4'd3:    sfn.chars[k] = padded[10];
                    default: sfn.chars[k] = '0;
                endcase
            end else begin
                sfn.chars[k] = '0;
            end
        end

        // Slots past the name are zero, so the first zero gives the length.
        sfn.len = SFN_LEN_W'(SFN_MAX);
        stop    = 1'b0;
        for (int k = 0; k < SFN_MAX; k++) begin
            if (!stop && sfn.chars[k] == '0) begin
                sfn.len = SFN_LEN_W'(k);
                stop    = 1'b1;
            end
        end
    end

endmodule

// File: design/fat_dir_entry_name_decoder_core.sv
// Top level of the FAT directory entry name decoder.
// Instantiates fdn_name_ram and fdn_short_name; depends on fdn_pkg.
//
// The block takes one raw 32-byte FAT directory entry per input transaction and
// returns the display name of each visible entry as a run of output transactions,
// one character each, with tlast on the final one. Every result also carries the
// directory flag, file size and first cluster. Long-name entries (attribute 0x0F)
// return nothing; they write the low bytes of their UTF-16 units into a character
// buffer, one unit per cycle. A visible entry with a pending long name reads that
// buffer back through its single registered read port; each character passes a
// holding register and then the output register, one character per cycle while
// m_tready is high. An entry without a long name shows its trimmed 8.3 name (at
// most 12 characters) from the output register at one character per cycle while
// m_tready is high. Deleted entries, volume labels and dot entries clear the
// pending long name. A first byte of zero gives one result with end_of_directory
// set; after it every entry is dropped until one arrives with new_directory set,
// which also clears the buffer, its length and the pending flag at once. The block
// accepts a new entry only when the previous one is fully handled, but a finished
// result may still be waiting in the output register at that time. Buffer writes
// and reads never overlap: writes happen only while a long-name entry is being
// stored, reads are used only while a name is being played out.
module fat_dir_entry_name_decoder_core #(
    parameter int NAME_CAPACITY = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, from bit 0: entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23,
    // entry_bytes_24_31, new_directory, zero padding.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fdn_pkg::IN_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0: name_char, char_position, from_long_name, is_directory,
    // entry size, starting cluster, end_of_directory, zero padding.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fdn_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import fdn_pkg::*;

    localparam int AW = $clog2(NAME_CAPACITY);
    localparam logic [LFN_POS_W-1:0] POS_LIMIT = LFN_POS_W'(NAME_CAPACITY - 1);

    fsm_state_t state_reg, state_next;

    // Directory state held between entries.
    logic [AW-1:0] len_reg, len_next;
    logic          pending_reg, pending_next;
    logic          ended_reg, ended_next;

    // Latched entry and per-entry working registers.
    logic [ENTRY_W-1:0]    entry_reg;
    logic [LFN_POS_W-1:0]  off_reg;
    logic [UNIT_IDX_W-1:0] unit_reg;
    logic [AW-1:0]         scan_len_reg;
    logic [AW-1:0]         idx_reg;
    logic [CHAR_W-1:0]     held_reg;
    logic                  have_held_reg, have_held_next;
    sfn_t                  sfn_reg;
    logic [SFN_LEN_W-1:0]  sidx_reg;
    logic                  from_long_reg;
    logic                  isdir_reg;
    logic [WORD_W-1:0]     size_reg;
    logic [WORD_W-1:0]     clus_reg;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_last_reg;

    // Input decode.
    logic              s_fire;
    logic              new_dir;
    logic [CHAR_W-1:0] b0;
    logic [CHAR_W-1:0] attr;
    logic [SEQ_W-1:0]  lfn_seq;
    logic              ended_eff;
    logic              pending_eff;
    logic [AW-1:0]     len_eff;
    logic              is_end, is_del, is_lfn, is_skip, is_vis;
    sfn_t              sfn;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid & s_tready;
    assign new_dir     = s_tdata[NEW_DIR_BIT];
    assign b0          = s_tdata[7:0];
    assign attr        = s_tdata[95:88];
    assign lfn_seq     = b0[SEQ_W-1:0];
    assign ended_eff   = ended_reg & ~new_dir;
    assign pending_eff = pending_reg & ~new_dir;
    assign len_eff     = new_dir ? '0 : len_reg;

    assign is_end  = (b0 == BYTE_END);
    assign is_del  = !is_end && (b0 == BYTE_DELETED);
    assign is_lfn  = !is_end && !is_del && (attr == ATTR_LONG);
    assign is_skip = !is_end && !is_del && !is_lfn &&
                     (((attr & ATTR_VOLUME) != '0) || (b0 == BYTE_DOT));
    assign is_vis  = !is_end && !is_del && !is_lfn && !is_skip;

    fdn_short_name u_short_name (
        .name_bytes (s_tdata[87:0]),
        .sfn        (sfn)
    );

    // Long-name unit currently being stored.
    logic [31:0][CHAR_W-1:0] entry_bytes;
    logic [4:0]              unit_ofs;
    logic [UNIT_W-1:0]       unit_val;
    logic [LFN_POS_W-1:0]    lfn_pos;
    logic                    lfn_stop;
    logic                    store_last;

    assign entry_bytes = entry_reg;
    assign unit_ofs    = UNIT_OFFSET[unit_reg];
    assign unit_val    = {entry_bytes[5'(unit_ofs + 5'd1)], entry_bytes[unit_ofs]};
    assign lfn_pos     = off_reg + LFN_POS_W'(unit_reg);
    assign lfn_stop    = (lfn_pos >= POS_LIMIT) || (unit_val == UNIT_EMPTY) ||
                         (unit_val == UNIT_PAD);
    assign store_last  = lfn_stop || (unit_reg == UNIT_LAST);

    // Character buffer.
    logic              ram_we;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] ram_rdata;

    fdn_name_ram #(
        .DEPTH (NAME_CAPACITY)
    ) u_name_ram (
        .clk     (aclk),
        .rst_n   (aresetn),
        .clear   (s_fire & new_dir),
        .wr_en   (ram_we),
        .wr_addr (lfn_pos[AW-1:0]),
        .wr_data (unit_val[CHAR_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // The scan ends at the stored length or at the first zero character.
    logic scan_end;
    logic scan_adv;
    logic slot_free;
    logic short_last;

    assign scan_end   = (idx_reg >= scan_len_reg) || (ram_rdata == '0);
    assign slot_free  = ~m_valid_reg | m_tready;
    assign short_last = (sfn_reg.len == '0) || (SFN_LEN_W'(sidx_reg + 1'b1) == sfn_reg.len);

    // Sequencer outputs.
    logic                  out_load;
    logic [CHAR_W-1:0]     o_char;
    logic [CHAR_POS_W-1:0] o_pos;
    logic                  o_eod;
    logic                  o_last;

    always_comb begin
        out_load = 1'b0;
        o_char   = '0;
        o_pos    = '0;
        o_eod    = 1'b0;
        o_last   = 1'b0;
        ram_we   = 1'b0;
        scan_adv = 1'b0;
        rd_addr  = '0;
        case (state_reg)
            ST_IDLE: begin
                rd_addr = '0;
            end
            ST_LFN_WRITE: begin
                ram_we = ~lfn_stop;
            end
            ST_LONG_SCAN: begin
                if (!have_held_reg) begin
                    // First character: an immediate end means an empty name.
                    scan_adv = ~scan_end;
                    out_load = scan_end & slot_free;
                    o_last   = 1'b1;
                end else if (slot_free) begin
                    out_load = 1'b1;
                    o_char   = held_reg;
                    o_pos    = CHAR_POS_W'(idx_reg - 1'b1);
                    o_last   = scan_end;
                    scan_adv = ~scan_end;
                end
                // On a stall the same address is read again so the data holds.
                rd_addr = scan_adv ? AW'(idx_reg + 1'b1) : idx_reg;
            end
            ST_SHORT_EMIT: begin
                out_load = slot_free;
                o_char   = (sfn_reg.len == '0) ? '0 : sfn_reg.chars[sidx_reg];
                o_pos    = CHAR_POS_W'(sidx_reg);
                o_last   = short_last;
            end
            ST_END_MARK: begin
                out_load = slot_free;
                o_eod    = 1'b1;
                o_last   = 1'b1;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && !ended_eff) begin
                    if (is_end) begin
                        state_next = ST_END_MARK;
                    end else if (is_lfn && lfn_seq != '0) begin
                        state_next = ST_LFN_WRITE;
                    end else if (is_vis) begin
                        state_next = pending_eff ? ST_LONG_SCAN : ST_SHORT_EMIT;
                    end
                end
            end
            ST_LFN_WRITE: begin
                if (store_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LONG_SCAN, ST_SHORT_EMIT: begin
                if (out_load && o_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_END_MARK: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Directory state updates.
    always_comb begin
        len_next       = len_reg;
        pending_next   = pending_reg;
        ended_next     = ended_reg;
        have_held_next = have_held_reg;
        if (s_fire) begin
            len_next       = len_eff;
            pending_next   = pending_eff;
            ended_next     = ended_eff;
            have_held_next = 1'b0;
            if (!ended_eff) begin
                if (is_lfn) begin
                    pending_next = 1'b1;
                end else begin
                    pending_next = 1'b0;
                    len_next     = '0;
                    if (is_end) begin
                        ended_next = 1'b1;
                    end
                end
            end
        end
        if (ram_we && ((lfn_pos + 1'b1) > LFN_POS_W'(len_reg))) begin
            len_next = AW'(lfn_pos + 1'b1);
        end
        if (state_reg == ST_LONG_SCAN && scan_adv) begin
            have_held_next = 1'b1;
        end
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pending_reg   <= 1'b0;
            ended_reg     <= 1'b0;
            have_held_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pending_reg   <= pending_next;
            ended_reg     <= ended_next;
            have_held_reg <= have_held_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            entry_reg     <= s_tdata[ENTRY_W-1:0];
            off_reg       <= LFN_POS_W'(lfn_seq - 1'b1) * LFN_POS_W'(UNITS_PER_ENTRY);
            unit_reg      <= '0;
            scan_len_reg  <= len_eff;
            idx_reg       <= '0;
            sfn_reg       <= sfn;
            sidx_reg      <= '0;
            from_long_reg <= pending_eff;
            isdir_reg     <= (attr & ATTR_DIRECTORY) != '0;
            size_reg      <= s_tdata[255:224];
            clus_reg      <= {s_tdata[175:160], s_tdata[223:208]};
        end else begin
            if (state_reg == ST_LFN_WRITE) begin
                unit_reg <= UNIT_IDX_W'(unit_reg + 1'b1);
            end
            if (state_reg == ST_LONG_SCAN) begin
                idx_reg <= rd_addr;
                if (scan_adv) begin
                    held_reg <= ram_rdata;
                end
            end
            if (state_reg == ST_SHORT_EMIT && out_load && !o_last) begin
                sidx_reg <= SFN_LEN_W'(sidx_reg + 1'b1);
            end
        end
        if (out_load) begin
            m_last_reg <= o_last;
            if (o_eod) begin
                m_data_reg <= {OUT_PAD_W'(0), 1'b1, WORD_W'(0), WORD_W'(0), 1'b0, 1'b0,
                               o_pos, o_char};
            end else begin
                m_data_reg <= {OUT_PAD_W'(0), 1'b0, clus_reg, size_reg, isdir_reg,
                               from_long_reg, o_pos, o_char};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    ap_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LONG_SCAN |-> idx_reg <= scan_len_reg)
        else $error("buffer scan ran past the stored name length");

    ap_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= NAME_CAPACITY - 1)
        else $error("long name length beyond buffer capacity");

    ap_end_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !ended_eff && is_end |=> state_reg == ST_END_MARK && ended_reg)
        else $error("end-of-directory entry not taken to the end marker");

    ap_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LFN_WRITE |-> !out_load && !scan_adv)
        else $error("output or buffer scan active while storing a long name");
`endif

endmodule

// File: verif/fdn_name_checker.sv
`timescale 1ns / 1ps
// Scoreboard for fat_dir_entry_name_decoder_core: watches both stream channels, predicts
// the display name characters of every accepted entry and compares each output transaction.
// Depends on fdn_pkg for the stream layout and the FAT byte codes.
module fdn_name_checker #(
    parameter int NAME_CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fdn_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fdn_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              chars_waiting
);
    import fdn_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Same bit order as m_tdata from bit 0 up, with tlast on top.
    typedef struct packed {
        logic                last;
        logic                eod;
        logic [WORD_W-1:0]   clus;
        logic [WORD_W-1:0]   size;
        logic                dir;
        logic                lng;
        logic [CHAR_POS_W-1:0] pos;
        logic [CHAR_W-1:0]   ch;
    } name_char_t;

    name_char_t  char_q[$];
    logic [7:0]  lfn_buf [0:NAME_CAPACITY-2];
    int          lfn_len;
    bit          lfn_pending;
    bit          dir_closed;
    int          fails;

    task automatic clear_long_name();
        lfn_pending = 1'b0;
        lfn_len     = 0;
    endtask

    task automatic clear_directory();
        for (int i = 0; i < NAME_CAPACITY - 1; i++) lfn_buf[i] = '0;
        clear_long_name();
        dir_closed = 1'b0;
    endtask

    // Updates the name state for one entry and queues the characters it yields.
    task automatic decode_entry(input logic [ENTRY_W-1:0] e, input logic new_dir);
        logic [7:0]  b [0:31];
        logic [7:0]  disp [0:NAME_CAPACITY-1];
        logic [15:0] unit;
        logic [7:0]  attr;
        name_char_t  r;
        int          n;
        int          i;
        int          pos;
        int          seq;
        bit          lng;
        for (i = 0; i < 32; i++) b[i] = e[i*8 +: 8];
        if (new_dir) clear_directory();
        if (dir_closed) return;
        attr = b[11];
        if (b[0] == BYTE_END) begin
            dir_closed = 1'b1;
            clear_long_name();
            r      = '0;
            r.eod  = 1'b1;
            r.last = 1'b1;
            char_q.push_back(r);
            return;
        end
        if (b[0] == BYTE_DELETED) begin
            clear_long_name();
            return;
        end
        if (attr == ATTR_LONG) begin
            seq = int'(b[0][SEQ_W-1:0]);
            if (seq != 0) begin
                for (i = 0; i < UNITS_PER_ENTRY; i++) begin
                    pos  = (seq - 1) * UNITS_PER_ENTRY + i;
                    unit = {b[int'(UNIT_OFFSET[i]) + 1], b[int'(UNIT_OFFSET[i])]};
                    if (pos >= NAME_CAPACITY - 1) break;
                    if (unit == UNIT_EMPTY || unit == UNIT_PAD) break;
                    lfn_buf[pos] = unit[7:0];
                    if (pos + 1 > lfn_len) lfn_len = pos + 1;
                end
            end
            lfn_pending = 1'b1;
            return;
        end
        if ((attr & ATTR_VOLUME) != '0 || b[0] == BYTE_DOT) begin
            clear_long_name();
            return;
        end

        lng = lfn_pending;
        n   = 0;
        if (lng) begin
            for (i = 0; i < lfn_len && i < NAME_CAPACITY - 1; i++) begin
                if (lfn_buf[i] == '0) break;
                disp[n] = lfn_buf[i];
                n++;
            end
        end else begin
            for (i = 0; i < 8 && b[i] != BYTE_SPACE; i++) begin
                disp[n] = b[i];
                n++;
            end
            if (b[8] != BYTE_SPACE) begin
                disp[n] = BYTE_DOT;
                n++;
                for (i = 8; i < 11 && b[i] != BYTE_SPACE; i++) begin
                    disp[n] = b[i];
                    n++;
                end
            end
            // A zero byte cuts the short name short.
            for (i = 0; i < n; i++) begin
                if (disp[i] == '0) begin
                    n = i;
                    break;
                end
            end
        end

        r      = '0;
        r.lng  = lng;
        r.dir  = (attr & ATTR_DIRECTORY) != '0;
        r.size = {b[31], b[30], b[29], b[28]};
        r.clus = {b[21], b[20], b[27], b[26]};
        clear_long_name();
        if (n == 0) begin
            r.last = 1'b1;
            char_q.push_back(r);
        end else begin
            for (i = 0; i < n; i++) begin
                r.ch   = disp[i];
                r.pos  = CHAR_POS_W'(i);
                r.last = (i == n - 1);
                char_q.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin
        name_char_t got;
        name_char_t want;
        if (!aresetn) begin
            char_q.delete();
            clear_directory();
            fails = 0;
        end else begin
            // Output first: a result at this edge can only belong to an earlier entry.
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[$bits(name_char_t)-2:0]};
                if (char_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected name character ch=%02h pos=%0d eod=%0d last=%0d",
                                 $time, got.ch, got.pos, got.eod, got.last);
                end else begin
                    want = char_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: mismatch, expected ch=%02h pos=%0d long=%0d dir=%0d",
                                     $time, want.ch, want.pos, want.lng, want.dir,
                                     " size=%08h clus=%08h eod=%0d last=%0d",
                                     want.size, want.clus, want.eod, want.last);
                            $display("%0t:           actual   ch=%02h pos=%0d long=%0d dir=%0d",
                                     $time, got.ch, got.pos, got.lng, got.dir,
                                     " size=%08h clus=%08h eod=%0d last=%0d",
                                     got.size, got.clus, got.eod, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_entry(s_tdata[ENTRY_W-1:0], s_tdata[NEW_DIR_BIT]);
        end
        fail_count    <= fails;
        chars_waiting <= char_q.size();
    end

endmodule

// File: verif/fat_dir_entry_name_decoder_core_test.sv
`timescale 1ns / 1ps
// Testbench top for fat_dir_entry_name_decoder_core: drives directory entries, runs the
// output back-pressure and prints the verdict. Depends on fdn_pkg and fdn_name_checker.
module fat_dir_entry_name_decoder_core_test;
    import fdn_pkg::*;

    localparam int NAME_CAPACITY = 64;
    // Long-name storing produces no result, so the quiet period after the last
    // expected character has to cover it.
    localparam int DRAIN_CYCLES  = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 195;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Order byte flag of the first stored (highest) long-name entry.
    localparam logic [7:0] LFN_LAST_FLAG = 8'h40;
    localparam logic [7:0] SEQ_ALL_ONES  = 8'h1F;
    localparam logic [7:0] ATTR_ARCHIVE  = 8'h20;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tlast;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int send_idle_pct = 13;
    int recv_idle_pct = 62;
    int items_sent    = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int fail_count;
    int chars_waiting;

    fat_dir_entry_name_decoder_core #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    fdn_name_checker #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .chars_waiting(chars_waiting)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or drops results.
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side. A hold request from the stimulus process keeps tready low while
    // the hold counter runs down; otherwise tready drops at random at the current rate.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] text_char();
        if ($urandom_range(3) == 0) return 8'($urandom_range(48, 57));
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [ENTRY_W-1:0] random_bits();
        logic [ENTRY_W-1:0] e;
        for (int k = 0; k < ENTRY_W / 32; k++) e[k*32 +: 32] = $urandom;
        return e;
    endfunction

    // End-of-directory marker: zero first byte, random remaining bytes.
    function automatic logic [ENTRY_W-1:0] end_entry();
        logic [ENTRY_W-1:0] e;
        e      = random_bits();
        e[7:0] = BYTE_END;
        return e;
    endfunction

    // Short (8.3) entry with the given base and extension lengths, space padded.
    // Size, cluster and the remaining bytes are random.
    function automatic logic [ENTRY_W-1:0] short_entry(int stem_len, int ext_len,
                                                       logic [7:0] attr);
        logic [ENTRY_W-1:0] e;
        e = random_bits();
        for (int i = 0; i < 8; i++) e[i*8 +: 8] = (i < stem_len) ? text_char() : BYTE_SPACE;
        for (int i = 0; i < 3; i++)
            e[(8 + i)*8 +: 8] = (i < ext_len) ? text_char() : BYTE_SPACE;
        e[11*8 +: 8] = attr;
        return e;
    endfunction

    // Long-name entry: n_chars text units, then the stop unit, then padding units.
    // The high byte of a unit is usually zero but now and then random.
    function automatic logic [ENTRY_W-1:0] lfn_entry(logic [7:0] order, int n_chars,
                                                     logic [UNIT_W-1:0] stop);
        logic [ENTRY_W-1:0] e;
        logic [UNIT_W-1:0]  unit;
        e = random_bits();
        e[7:0]       = order;
        e[11*8 +: 8] = ATTR_LONG;
        for (int u = 0; u < UNITS_PER_ENTRY; u++) begin
            if (u < n_chars)
                unit = {($urandom_range(9) == 0) ? 8'($urandom) : 8'h00, text_char()};
            else if (u == n_chars)
                unit = stop;
            else
                unit = UNIT_PAD;
            e[int'(UNIT_OFFSET[u])*8 +: UNIT_W] = unit;
        end
        return e;
    endfunction

    function automatic logic [ENTRY_W-1:0] visible_entry();
        int stem_len;
        stem_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        return short_entry(stem_len, $urandom_range(0, 3), 8'($urandom) & ~ATTR_VOLUME);
    endfunction

    // Deleted, volume label or dot entry, picked at random.
    function automatic logic [ENTRY_W-1:0] skip_entry();
        logic [ENTRY_W-1:0] e;
        e = visible_entry();
        case ($urandom_range(2))
            0:       e[7:0]       = BYTE_DELETED;
            1:       e[11*8 +: 8] = 8'($urandom) | ATTR_VOLUME;
            default: e[7:0]       = BYTE_DOT;
        endcase
        return e;
    endfunction

    // Offers one entry and returns at the edge where it is accepted. Idle cycles
    // before the offer drop tvalid; tvalid is never lowered and raised in one step.
    task automatic send_entry(input logic [ENTRY_W-1:0] e, input logic new_dir);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - NEW_DIR_BIT - 1){1'b0}}, new_dir, e};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // The sender pauses until every predicted character has come out, then lets the
    // block finish any long-name storing that produces nothing.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random traffic, mostly well-formed directories: long-name chains in descending
    // order followed by their short entry, plain short entries, skipped entries, end
    // markers with a fresh directory after them, and some raw noise.
    task automatic random_groups(input int quota);
        int          first_item;
        int          kind;
        int          n;
        int          k;
        logic [7:0]  order;
        first_item = items_sent;
        while (items_sent - first_item < quota) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                n = $urandom_range(1, 6);
                for (k = n; k >= 1; k--) begin
                    // Now and then a link of the chain goes missing.
                    if ($urandom_range(9) == 0) continue;
                    order = 8'(k);
                    if (k == n) order |= LFN_LAST_FLAG;
                    if ($urandom_range(19) == 0) order = 8'($urandom_range(0, 31));
                    send_entry(lfn_entry(order,
                                         (k == n) ? $urandom_range(0, 13) : UNITS_PER_ENTRY,
                                         $urandom_range(1) ? UNIT_PAD : UNIT_EMPTY), 1'b0);
                end
                if ($urandom_range(9) == 0) send_entry(skip_entry(), 1'b0);
                else                        send_entry(visible_entry(), 1'b0);
            end else if (kind < 70) begin
                send_entry(visible_entry(), 1'b0);
            end else if (kind < 80) begin
                send_entry(skip_entry(), 1'b0);
            end else if (kind < 85) begin
                send_entry(end_entry(), 1'b0);
                // Entries after the end marker are dropped until a new directory.
                if ($urandom_range(2) == 0) send_entry(visible_entry(), 1'b0);
                send_entry(visible_entry(), 1'b1);
            end else if (kind < 93) begin
                send_entry(random_bits(), $urandom_range(9) == 0);
            end else begin
                send_entry(visible_entry(), 1'b1);
            end
        end
    endtask

    initial begin
        logic [ENTRY_W-1:0] e;
        int                 k;
        int                 phase;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. One-letter name in a fresh directory.
        send_entry(short_entry(1, 0, ATTR_ARCHIVE), 1'b1);
        // Full 8.3 directory name with all-ones size and cluster.
        e = short_entry(8, 3, ATTR_DIRECTORY);
        e[255:224] = '1;
        e[175:160] = '1;
        e[223:208] = '1;
        send_entry(e, 1'b0);
        // Blank base and extension: one empty-name result.
        send_entry(short_entry(0, 0, ATTR_ARCHIVE), 1'b0);
        // Zero byte inside the short name ends it early; size and cluster zero.
        e = short_entry(8, 3, '0);
        e[3*8 +: 8] = '0;
        e[255:224]  = '0;
        e[175:160]  = '0;
        e[223:208]  = '0;
        send_entry(e, 1'b0);
        // Deleted entry, volume label and dot entry give nothing.
        e = short_entry(4, 3, ATTR_ARCHIVE);
        e[7:0] = BYTE_DELETED;
        send_entry(e, 1'b0);
        send_entry(short_entry(8, 3, ATTR_VOLUME), 1'b0);
        e = short_entry(1, 0, ATTR_DIRECTORY);
        e[7:0] = BYTE_DOT;
        send_entry(e, 1'b0);
        // Two-entry long name; a unit with a zero low byte cuts it inside the second.
        send_entry(lfn_entry(LFN_LAST_FLAG | 8'd2, UNITS_PER_ENTRY, UNIT_EMPTY), 1'b0);
        e = lfn_entry(8'd1, UNITS_PER_ENTRY, UNIT_EMPTY);
        e[int'(UNIT_OFFSET[7])*8 +: UNIT_W] = 16'h0100;
        send_entry(e, 1'b0);
        send_entry(short_entry(6, 3, ATTR_ARCHIVE), 1'b0);
        // Order field of zero: nothing stored, but the long name is pending.
        send_entry(lfn_entry(LFN_LAST_FLAG, UNITS_PER_ENTRY, UNIT_PAD), 1'b0);
        send_entry(short_entry(5, 2, ATTR_ARCHIVE), 1'b0);
        // Five entries fill the buffer; characters at the capacity limit are dropped.
        for (k = 5; k >= 1; k--)
            send_entry(lfn_entry((k == 5) ? (LFN_LAST_FLAG | 8'(k)) : 8'(k),
                                 UNITS_PER_ENTRY, UNIT_PAD), 1'b0);
        send_entry(short_entry(8, 3, ATTR_DIRECTORY), 1'b0);
        // Second entry alone: the first 13 positions show stale buffer bytes.
        send_entry(lfn_entry(LFN_LAST_FLAG | 8'd2, 4, UNIT_PAD), 1'b0);
        send_entry(short_entry(3, 0, ATTR_ARCHIVE), 1'b0);
        // Order far beyond the buffer stores nothing.
        send_entry(lfn_entry(LFN_LAST_FLAG | SEQ_ALL_ONES, UNITS_PER_ENTRY, UNIT_EMPTY), 1'b0);
        send_entry(short_entry(2, 1, ATTR_ARCHIVE), 1'b0);
        // End marker, then entries that must be dropped.
        send_entry(end_entry(), 1'b0);
        send_entry(short_entry(4, 3, ATTR_ARCHIVE), 1'b0);
        send_entry(lfn_entry(LFN_LAST_FLAG | 8'd1, 5, UNIT_EMPTY), 1'b0);
        // A new directory clears the buffer: a second-entry-only long name is empty.
        send_entry(lfn_entry(LFN_LAST_FLAG | 8'd2, UNITS_PER_ENTRY, UNIT_PAD), 1'b1);
        send_entry(short_entry(7, 3, ATTR_ARCHIVE), 1'b0);
        wait_drained();

        // Random part in three idle phases: slow receiver, slow sender, no idling.
        // In the last two phases the receiver also holds off for a long stretch while
        // the sender keeps offering, so the block backs up and stalls its input.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 13;
                    recv_idle_pct <= 62;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_idle_pct <= 13;
                    hold_asks     <= hold_asks + 1;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_idle_pct <= 0;
                    hold_asks     <= hold_asks + 1;
                end
            endcase
            random_groups(RANDOM_ITEMS / 3);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
